### hw/rtl/fbba_pkg.sv
`timescale 1ns / 1ps

package fbba_pkg;

  // Field widths fixed by the interface.
  localparam int NUM_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int NBLK_CFG_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // Request kinds.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BLOCKS_IN_USE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [NUM_W-1:0]      DATA_BASE_RST         = 32'd1;
  localparam logic [NBLK_CFG_W-1:0] MAP_BLOCKS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic             mode;
    logic [NUM_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0]    allocated_block;
    logic [STATUS_W-1:0] status;
    logic                map_dirty;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic prep;
    logic scan;
    logic alloc_write;
    logic free_check;
    logic free_write;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic scan_hit;
    logic scan_done;
    logic free_ok;
  } sts_t;

endpackage

### hw/rtl/free_block_bitmap_allocator.sv
`timescale 1ns / 1ps

// Free-block bitmap allocator with a next-fit search hint.
//
// A request is taken on a clock edge where start is high and busy is low.
// req.mode selects allocate (scan for the first clear bit, starting at the
// map block holding the hint) or free (clear the bit of req.block_number).
// The result appears on result for exactly one cycle with done high; the
// receiver cannot hold it off, so it must take it in that cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// writes it only while the block is idle, which the block does not enforce.
// Index 0 gives the block number of map bit 0, index 1 the map blocks searched.
//
// A free passes the prep, check and write states before done (a null or
// out-of-range free skips the write), and the next request can be taken
// in the cycle after done. An allocate takes longer for each map word read,
// and for each map block left early because its clear bits lie past the
// usable range; the single memory read port scans one word per cycle,
// save where a map block is left early. A full map costs a read of every
// word in use. Reset: the free map is cleared by a pass of one word per
// cycle over all 1024 words with the default sizes, while busy is high.
module free_block_bitmap_allocator import fbba_pkg::*; #(
  parameter int BITS_PER_MAP_BLOCK = 8192,
  parameter int MAX_MAP_BLOCKS     = 8,
  parameter int WORD_BITS          = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  req_t                  req,
  output logic                  busy,
  output logic                  done,
  output rsp_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fbba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Map memory, scan pipeline and result register.
  fbba_datapath #(
    .BITS_PER_MAP_BLOCK (BITS_PER_MAP_BLOCK),
    .MAX_MAP_BLOCKS     (MAX_MAP_BLOCKS),
    .WORD_BITS          (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .result    (result)
  );

endmodule

### hw/rtl/fbba_ctrl.sv
`timescale 1ns / 1ps

module fbba_ctrl import fbba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_AWRITE = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_FWRITE = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = sts.is_free ? S_FCHK : S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_hit) state_next = S_AWRITE;
        else if (sts.scan_done) state_next = S_DONE;
      end
      S_AWRITE: state_next = S_DONE;
      S_FCHK: begin
        state_next = sts.free_ok ? S_FWRITE : S_DONE;
      end
      S_FWRITE: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass over the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd             = '0;
    cmd.clear       = (state == S_CLEAR);
    cmd.load        = (state == S_IDLE) && start;
    cmd.prep        = (state == S_PREP);
    cmd.scan        = (state == S_SCAN);
    cmd.alloc_write = (state == S_AWRITE);
    cmd.free_check  = (state == S_FCHK);
    cmd.free_write  = (state == S_FWRITE);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

`ifndef NO_ASSERTIONS
  // The clearing pass holds off requests right after reset.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // An accepted request keeps the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // Exactly one result per request: the strobe drops straight after it rises.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

### hw/rtl/fbba_datapath.sv
`timescale 1ns / 1ps

module fbba_datapath import fbba_pkg::*; #(
  parameter int BITS_PER_MAP_BLOCK = 8192,
  parameter int MAX_MAP_BLOCKS     = 8,
  parameter int WORD_BITS          = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  req_t                  req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sts_t                  sts,
  output rsp_t                  result
);

  localparam int WPB         = BITS_PER_MAP_BLOCK / WORD_BITS;
  localparam int TOTAL_WORDS = MAX_MAP_BLOCKS * WPB;
  localparam int TOTAL_BITS  = MAX_MAP_BLOCKS * BITS_PER_MAP_BLOCK;
  localparam int REL_W       = $clog2(TOTAL_BITS);
  localparam int LIM_W       = REL_W + 1;
  localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int BLK_W       = (MAX_MAP_BLOCKS > 1) ? $clog2(MAX_MAP_BLOCKS) : 1;
  localparam int NB_W        = $clog2(MAX_MAP_BLOCKS + 1);
  localparam int WW          = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int WW_SH       = $clog2(WPB);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int BLK_SH      = $clog2(BITS_PER_MAP_BLOCK);

  // Configuration registers.
  logic [NUM_W-1:0]      data_base;
  logic [NBLK_CFG_W-1:0] map_blocks_in_use;

  // Effective configuration and the usable bit count.
  logic [NUM_W-1:0] eff_first;
  logic [NB_W-1:0]  nblk;
  logic [LIM_W-1:0] span;
  logic [NUM_W:0]   room;
  logic [LIM_W-1:0] limit_next;
  logic [LIM_W-1:0] limit_q;

  // Latched request and persistent state.
  req_t             req_q;
  logic [REL_W-1:0] hint;
  logic             dirty;
  rsp_t             res;

  // Free-map memory.
  logic [WORD_BITS-1:0] mem [TOTAL_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]    clr_addr;

  // Scan issue stage.
  logic              iss_active;
  logic [BLK_W-1:0]  iss_blk;
  logic [WW-1:0]     iss_w;
  logic [NB_W-1:0]   iss_k;
  logic [ADDR_W-1:0] iss_addr;
  logic [BLK_W-1:0]  iss_blk_wrap;
  logic [REL_W-1:0]  hint_blk;
  logic [BLK_W-1:0]  start_blk;

  // Scan evaluate stage.
  logic              tag_valid;
  logic [ADDR_W-1:0] tag_addr;
  logic [BLK_W-1:0]  tag_blk;
  logic [NB_W-1:0]   tag_k;
  logic [BLK_W-1:0]  tag_blk_wrap;
  logic [BIT_W-1:0]  ffz_b;
  logic [REL_W-1:0]  eval_rel;
  logic              eval_nz;
  logic              eval_in;
  logic              eval_hit;
  logic              eval_skip;

  // Hit held for the write-back.
  logic [REL_W-1:0]     hit_rel;
  logic [ADDR_W-1:0]    hit_addr;
  logic [WORD_BITS-1:0] hit_word;

  // Free checks.
  logic             f_null;
  logic             f_below;
  logic [NUM_W-1:0] f_rel;
  logic             free_ok;
  logic [ADDR_W-1:0] free_addr;
  logic [BIT_W-1:0]  free_bit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_base         <= DATA_BASE_RST;
      map_blocks_in_use <= MAP_BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_BASE:         data_base         <= cfg_data;
        CFG_MAP_BLOCKS_IN_USE: map_blocks_in_use <= cfg_data[NBLK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration and work out how many map bits may be used.
  always_comb begin
    eff_first = (data_base == '0) ? NUM_W'(1) : data_base;
    if (map_blocks_in_use == '0) begin
      nblk = NB_W'(1);
    end else if (32'(map_blocks_in_use) > 32'(MAX_MAP_BLOCKS)) begin
      nblk = NB_W'(MAX_MAP_BLOCKS);
    end else begin
      nblk = NB_W'(map_blocks_in_use);
    end
    span = LIM_W'(nblk) << BLK_SH;
    room = {1'b1, {NUM_W{1'b0}}} - {1'b0, eff_first};
    limit_next = (room < (NUM_W + 1)'(span)) ? LIM_W'(room) : span;
  end

  always_ff @(posedge clk) begin
    limit_q <= limit_next;
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
  end

  // Start block from the hint, falling back to block zero.
  assign hint_blk  = hint >> BLK_SH;
  assign start_blk = (hint_blk >= REL_W'(nblk)) ? '0 : BLK_W'(hint_blk);

  assign iss_addr     = (ADDR_W'(iss_blk) << WW_SH) | ADDR_W'(iss_w);
  assign iss_blk_wrap = ((NB_W'(iss_blk) + NB_W'(1)) == nblk) ? '0 : iss_blk + BLK_W'(1);
  assign tag_blk_wrap = ((NB_W'(tag_blk) + NB_W'(1)) == nblk) ? '0 : tag_blk + BLK_W'(1);

  // Find the lowest clear bit of the word under evaluation.
  always_comb begin
    ffz_b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data[i]) ffz_b = BIT_W'(i);
    end
  end

  assign eval_rel  = (REL_W'(tag_addr) << BIT_W) | REL_W'(ffz_b);
  assign eval_nz   = tag_valid && !(&rd_data);
  assign eval_in   = ({1'b0, eval_rel} < limit_q);
  assign eval_hit  = cmd.scan && eval_nz && eval_in;
  assign eval_skip = cmd.scan && eval_nz && !eval_in;

  // Scan pipeline: one word read per cycle save on a skip, evaluated the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_active <= 1'b0;
      tag_valid  <= 1'b0;
    end else if (cmd.prep) begin
      iss_active <= 1'b1;
      iss_blk    <= start_blk;
      iss_w      <= '0;
      iss_k      <= '0;
      tag_valid  <= 1'b0;
    end else if (cmd.scan) begin
      if (eval_hit) begin
        iss_active <= 1'b0;
        tag_valid  <= 1'b0;
      end else if (eval_skip) begin
        // The rest of this map block lies past the usable bits.
        tag_valid <= 1'b0;
        if (tag_k == nblk - NB_W'(1)) begin
          iss_active <= 1'b0;
        end else begin
          iss_active <= 1'b1;
          iss_blk    <= tag_blk_wrap;
          iss_w      <= '0;
          iss_k      <= tag_k + NB_W'(1);
        end
      end else begin
        tag_valid <= iss_active;
        tag_addr  <= iss_addr;
        tag_blk   <= iss_blk;
        tag_k     <= iss_k;
        if (iss_active) begin
          if (iss_w == WW'(WPB - 1)) begin
            iss_w <= '0;
            if (iss_k == nblk - NB_W'(1)) begin
              iss_active <= 1'b0;
            end else begin
              iss_k   <= iss_k + NB_W'(1);
              iss_blk <= iss_blk_wrap;
            end
          end else begin
            iss_w <= iss_w + WW'(1);
          end
        end
      end
    end
  end

  // Hold the hit for the write-back cycle.
  always_ff @(posedge clk) begin
    if (eval_hit) begin
      hit_rel  <= eval_rel;
      hit_addr <= tag_addr;
      hit_word <= rd_data | (WORD_BITS'(1) << ffz_b);
    end
  end

  // Free request checks, registered before the range compare.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      f_null  <= (req_q.block_number == '0);
      f_below <= (req_q.block_number < eff_first);
      f_rel   <= req_q.block_number - eff_first;
    end
  end

  assign free_ok   = !f_null && !f_below && (f_rel < NUM_W'(limit_q));
  assign free_addr = ADDR_W'(f_rel[REL_W-1:0] >> BIT_W);
  assign free_bit  = f_rel[BIT_W-1:0];

  // Memory port selection.
  assign rd_addr = cmd.free_check ? free_addr : iss_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_write) begin
      wr_en   = 1'b1;
      wr_addr = hit_addr;
      wr_data = hit_word;
    end else if (cmd.free_write) begin
      wr_en   = 1'b1;
      wr_addr = free_addr;
      wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Hint and dirty flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hint  <= '0;
      dirty <= 1'b0;
    end else begin
      if (cmd.alloc_write) begin
        hint  <= hit_rel;
        dirty <= 1'b1;
      end else if (cmd.free_check && free_ok && (f_rel[REL_W-1:0] < hint)) begin
        hint <= f_rel[REL_W-1:0];
      end
      if (cmd.free_write) dirty <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.alloc_write) begin
      res.allocated_block <= eff_first + NUM_W'(hit_rel);
      res.status          <= ST_OK;
      res.map_dirty       <= 1'b1;
    end else if (cmd.free_write) begin
      res.allocated_block <= '0;
      res.status          <= ST_OK;
      res.map_dirty       <= 1'b1;
    end else if (cmd.free_check && !free_ok) begin
      res.allocated_block <= '0;
      res.status          <= f_null ? ST_NULL : ST_RANGE;
      res.map_dirty       <= dirty;
    end else if (cmd.scan && sts.scan_done) begin
      res.allocated_block <= '0;
      res.status          <= ST_FULL;
      res.map_dirty       <= dirty;
    end
  end

  assign result = res;

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.clear_last = (clr_addr == ADDR_W'(TOTAL_WORDS - 1));
    sts.is_free    = (req_q.mode == MODE_FREE);
    sts.scan_hit   = eval_hit;
    sts.scan_done  = !iss_active && !tag_valid;
    sts.free_ok    = free_ok;
  end

`ifndef NO_ASSERTIONS
  // Every allocate or free write to the map leaves the dirty flag set.
  a_dirty_after_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_write || cmd.free_write) |=> dirty)
    else $error("dirty flag not set after a map write");

  // A hit is always the first clear bit found inside the usable range.
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    eval_hit |=> ({1'b0, hit_rel} < limit_q))
    else $error("allocation past the usable bits");
`endif

endmodule

### dv/fbba_result_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the allocator, keeps its
// own copy of the free map, the search hint and the dirty flag, and compares
// every result with the one expected for the oldest accepted request.
module fbba_result_checker import fbba_pkg::*; #(
  parameter int BITS_PER_MAP_BLOCK = 8192,
  parameter int MAX_MAP_BLOCKS     = 8,
  parameter int WORD_BITS          = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  req_t                  req,
  input  logic                  busy,
  input  logic                  done,
  input  rsp_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    outstanding
);

  localparam int WORDS_PER_BLOCK = BITS_PER_MAP_BLOCK / WORD_BITS;
  localparam int TOTAL_WORDS     = MAX_MAP_BLOCKS * WORDS_PER_BLOCK;

  // Shadow of the allocator state and its registers.
  logic [WORD_BITS-1:0]  map_word [TOTAL_WORDS];
  logic [31:0]           hint_bit;
  logic                  dirty;
  logic [NUM_W-1:0]      first_reg;
  logic [NBLK_CFG_W-1:0] nblk_reg;

  rsp_t pending_results [$];
  int   mismatch_count;

  // Block number of map bit 0; zero would collide with the null block.
  function automatic logic [NUM_W-1:0] base_block();
    return (first_reg == '0) ? 32'd1 : first_reg;
  endfunction

  function automatic int unsigned blocks_searched();
    if (nblk_reg == '0) return 1;
    if (nblk_reg > MAX_MAP_BLOCKS) return MAX_MAP_BLOCKS;
    return 32'(nblk_reg);
  endfunction

  // Map bits that may hold a block: bounded by the map blocks in use and by
  // the top of the 32-bit block number space.
  function automatic logic [32:0] usable_bits();
    logic [32:0] span;
    logic [32:0] room;
    span = 33'(blocks_searched()) * BITS_PER_MAP_BLOCK;
    room = 33'h1_0000_0000 - {1'b0, base_block()};
    return (span < room) ? span : room;
  endfunction

  // Next-fit search: start at the map block holding the hint, take the lowest
  // clear bit of the first word that is not full, and give up on a map block
  // as soon as that bit lies past the usable range.
  function automatic rsp_t predict_alloc();
    rsp_t        r;
    int unsigned nblk;
    int unsigned start_blk;
    int unsigned blk;
    int unsigned wi;
    int unsigned b;
    logic [32:0] usable;
    logic [32:0] rel;
    bit          found;
    bit          leave;
    r = '0;
    r.status = ST_FULL;
    nblk = blocks_searched();
    usable = usable_bits();
    start_blk = hint_bit / BITS_PER_MAP_BLOCK;
    if (start_blk >= nblk) start_blk = 0;
    found = 1'b0;
    for (int k = 0; k < nblk && !found; k++) begin
      blk = (start_blk + k) % nblk;
      leave = 1'b0;
      for (int w = 0; w < WORDS_PER_BLOCK && !leave; w++) begin
        wi = blk * WORDS_PER_BLOCK + w;
        if (~map_word[wi] != '0) begin
          b = 0;
          while (map_word[wi][b]) b++;
          rel = 33'(wi) * WORD_BITS + b;
          leave = 1'b1;
          if (rel < usable) begin
            found = 1'b1;
            map_word[wi][b] = 1'b1;
            hint_bit = rel[31:0];
            dirty = 1'b1;
            r.allocated_block = base_block() + rel[31:0];
            r.status = ST_OK;
          end
        end
      end
    end
    r.map_dirty = dirty;
    return r;
  endfunction

  // A free clears the bit even when it is already clear, and pulls the hint
  // down to the freed block.
  function automatic rsp_t predict_free(input logic [NUM_W-1:0] num);
    rsp_t        r;
    logic [32:0] rel;
    r = '0;
    if (num == '0) begin
      r.status = ST_NULL;
    end else if (num < base_block()) begin
      r.status = ST_RANGE;
    end else begin
      rel = num - base_block();
      if (rel >= usable_bits()) begin
        r.status = ST_RANGE;
      end else begin
        if (rel[31:0] < hint_bit) hint_bit = rel[31:0];
        map_word[rel / WORD_BITS][rel % WORD_BITS] = 1'b0;
        dirty = 1'b1;
        r.status = ST_OK;
      end
    end
    r.map_dirty = dirty;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < TOTAL_WORDS; i++) map_word[i] = '0;
      hint_bit = '0;
      dirty = 1'b0;
      first_reg = DATA_BASE_RST;
      nblk_reg = MAP_BLOCKS_IN_USE_RST;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      // Results are compared before a request taken at the same edge is
      // predicted, since they belong to an earlier request.
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: allocated_block %0d, status %0d",
                 result.allocated_block, result.status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.allocated_block !== want.allocated_block) begin
            $error("allocated_block mismatch: expected %0d, got %0d",
                   want.allocated_block, result.allocated_block);
            mismatch_count++;
          end
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, result.status);
            mismatch_count++;
          end
          if (result.map_dirty !== want.map_dirty) begin
            $error("map_dirty mismatch: expected %0d, got %0d",
                   want.map_dirty, result.map_dirty);
            mismatch_count++;
          end
        end
      end

      // Register writes only arrive while the block is idle.
      if (cfg_we) begin
        if (cfg_index == CFG_DATA_BASE) first_reg = cfg_data[NUM_W-1:0];
        else if (cfg_index == CFG_MAP_BLOCKS_IN_USE) nblk_reg = cfg_data[NBLK_CFG_W-1:0];
      end

      if (start && !busy) begin
        if (req.mode == MODE_ALLOC) pending_results.push_back(predict_alloc());
        else pending_results.push_back(predict_free(req.block_number));
      end
    end
    failures <= mismatch_count;
    outstanding <= pending_results.size();
  end

endmodule

### dv/free_block_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

// Drives allocate and free requests into the allocator under several register
// settings and sender idling patterns; the checker beside the block predicts
// and compares every result. The run ends by filling a small map at the top
// of the block number space until it reports full, then freeing one block
// and taking it back.
module free_block_bitmap_allocator_tb;
  import fbba_pkg::*;

  localparam int BITS_PER_MAP_BLOCK = 8192;
  localparam int MAX_MAP_BLOCKS     = 8;
  localparam int STALL_LIMIT        = 10000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  req_t                  req = '0;
  logic                  busy;
  logic                  done;
  rsp_t                  result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DATA_BASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    failures;
  int                    outstanding;
  int                    full_results = 0;
  int                    quiet_cycles = 0;

  // Effective register values, used only to aim free requests.
  logic [NUM_W-1:0] lowest_block;
  logic [32:0]      map_span;

  free_block_bitmap_allocator uut (.*);

  fbba_result_checker result_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("free_block_bitmap_allocator_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Map-full results tell the fill sequence when to stop.
  always @(posedge clk) begin
    if (!rst && done && result.status == ST_FULL) full_results <= full_results + 1;
  end

  // Presents one request and returns at the edge that accepts it; start is
  // left high so back-to-back requests need no second assignment.
  task automatic send_request(input logic mode_bit, input logic [NUM_W-1:0] num);
    start <= 1'b1;
    req <= '{mode: mode_bit, block_number: num};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every expected result has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // Writes both registers on consecutive edges.
  task automatic configure(input logic [NUM_W-1:0] first_value,
                           input logic [CFG_DATA_W-1:0] blocks_value);
    int unsigned nblk;
    logic [32:0] room;
    cfg_we <= 1'b1;
    cfg_index <= CFG_DATA_BASE;
    cfg_data <= first_value;
    @(posedge clk);
    cfg_index <= CFG_MAP_BLOCKS_IN_USE;
    cfg_data <= blocks_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lowest_block = (first_value == '0) ? 32'd1 : first_value;
    nblk = blocks_value[NBLK_CFG_W-1:0];
    if (nblk == 0) nblk = 1;
    if (nblk > MAX_MAP_BLOCKS) nblk = MAX_MAP_BLOCKS;
    room = 33'h1_0000_0000 - {1'b0, lowest_block};
    map_span = 33'(nblk) * BITS_PER_MAP_BLOCK;
    if (room < map_span) map_span = room;
  endtask

  // Random requests: mostly allocations and frees close to the low end of the
  // map, where allocated blocks live, plus null frees, range edges and noise.
  task automatic run_phase(input int count, input int idle_pct);
    int unsigned      pick;
    logic [NUM_W-1:0] num;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        req <= {$urandom_range(1) == 1, $urandom};
        @(posedge clk);
      end
      pick = $urandom_range(99);
      num = $urandom;
      if (pick < 55) begin
        send_request(MODE_ALLOC, num);
      end else if (pick < 85) begin
        send_request(MODE_FREE, lowest_block + $urandom_range(0, 159));
      end else if (pick < 90) begin
        send_request(MODE_FREE, '0);
      end else if (pick < 95) begin
        case ($urandom_range(2))
          0: send_request(MODE_FREE, lowest_block - 1);
          1: send_request(MODE_FREE, lowest_block + map_span[31:0] - 1);
          default: send_request(MODE_FREE, lowest_block + map_span[31:0]);
        endcase
      end else begin
        send_request(MODE_FREE, num);
      end
    end
  endtask

  initial begin
    int base;
    lowest_block = DATA_BASE_RST;
    map_span = 33'(MAP_BLOCKS_IN_USE_RST) * BITS_PER_MAP_BLOCK;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: null and out-of-range frees leave the map clean, then
    // allocation order, hint lowering, freeing a free block and the map end.
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, 32'h5555_5555);
    send_request(MODE_FREE, 32'd2);
    send_request(MODE_ALLOC, 32'hAAAA_AAAA);
    send_request(MODE_FREE, 32'd500);
    send_request(MODE_FREE, 32'd65536);
    send_request(MODE_FREE, 32'd65537);
    drain();

    // Zero in both registers is taken as one.
    configure('0, '0);
    send_request(MODE_FREE, 32'd8193);
    send_request(MODE_FREE, 32'd8192);
    send_request(MODE_ALLOC, '0);
    drain();

    // Top of the block number space: a single usable bit, map blocks clamped.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 32'hFFFF_FFFE);
    drain();

    // Random phases under different settings and sender idling.
    configure(32'd1, 32'd8);
    run_phase(200, 0);
    drain();
    configure(32'd1000, {28'($urandom), 4'd3});
    run_phase(200, 46);
    drain();
    configure(32'hFFFF_FF80, 32'd8);
    run_phase(200, 0);
    drain();
    configure($urandom_range(2, 50000), {28'($urandom), 4'($urandom_range(1, 8))});
    run_phase(200, 8);
    drain();

    // Fill the last 32 block numbers until the map reports full, then free
    // one of them and allocate it again.
    configure(32'hFFFF_FFE0, 32'd1);
    base = full_results;
    for (int n = 0; n < 64 && full_results == base; n++) begin
      send_request(MODE_ALLOC, $urandom);
    end
    drain();
    send_request(MODE_FREE, 32'hFFFF_FFE6);
    send_request(MODE_ALLOC, $urandom);
    drain();

    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("free_block_bitmap_allocator_tb passed");
    end else begin
      $display("free_block_bitmap_allocator_tb failed");
    end
    $finish;
  end

endmodule
